// File: design/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define HCFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset
`define HCFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hcfp_pkg.sv
`timescale 1ns / 1ps

package hcfp_pkg;

  localparam int W_IN     = 16;
  localparam int W_PITCH  = 20;
  localparam int W_RECIP  = 24;
  localparam int W_CFG    = 24;
  localparam int W_IDX    = 16;
  localparam int W_OUTC   = 25;
  localparam int W_SCALED = W_IN + W_RECIP + 1;
  localparam int W_CTR    = 38;
  localparam int W_D      = W_CTR - 1;
  localparam int D_LO     = 19;
  localparam int D_HI     = W_D - D_LO;
  localparam int W_SQ     = 2 * W_D + 1;
  localparam int FRAC_Q24 = 24;

  // input capture, scale, index, product, center, 4 in distance unit, output
  localparam int LATENCY  = 10;
  localparam int SIDE_DEPTH = 3;

  localparam logic [W_PITCH-1:0] COL_PITCH_RST = 20'd8868;
  localparam logic [W_PITCH-1:0] ROW_PITCH_RST = 20'd15360;
  localparam logic [W_RECIP-1:0] COL_RECIP_RST = 24'd484322;
  localparam logic [W_RECIP-1:0] ROW_RECIP_RST = 24'd279620;

  localparam logic signed [W_SCALED-1:0] HALF_Q24 = W_SCALED'(64'd1 << (FRAC_Q24 - 1));
  localparam logic signed [W_CTR-1:0] CENTER_MAX = W_CTR'(64'd16777215);
  localparam logic signed [W_CTR-1:0] CENTER_MIN = -W_CTR'(64'd16777216);

  typedef enum logic [1:0] {
    REG_COL_PITCH = 2'd0,
    REG_ROW_PITCH = 2'd1,
    REG_COL_RECIP = 2'd2,
    REG_ROW_RECIP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [W_IDX-1:0]  col_sh;
    logic signed [W_IDX-1:0]  row_sh;
    logic signed [W_IDX-1:0]  col_un;
    logic signed [W_IDX-1:0]  row_un;
    logic signed [W_OUTC-1:0] cx_sh;
    logic signed [W_OUTC-1:0] cy_sh;
    logic signed [W_OUTC-1:0] cx_un;
    logic signed [W_OUTC-1:0] cy_un;
  } side_t;

  function automatic logic signed [W_OUTC-1:0] sat_center(input logic signed [W_CTR-1:0] v);
    logic signed [W_OUTC-1:0] r;
    if (v > CENTER_MAX) begin
      r = W_OUTC'(CENTER_MAX);
    end else if (v < CENTER_MIN) begin
      r = W_OUTC'(CENTER_MIN);
    end else begin
      r = v[W_OUTC-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/hcfp_dist_sq.sv
`timescale 1ns / 1ps

// squared distance, four register stages
module hcfp_dist_sq import hcfp_pkg::*; (
  input  logic                    clk,
  input  logic signed [W_CTR-1:0] cx,
  input  logic signed [W_CTR-1:0] cy,
  input  logic signed [W_CTR-1:0] px,
  input  logic signed [W_CTR-1:0] py,
  output logic        [W_SQ-1:0]  dsq
);

  logic signed [W_CTR-1:0] dx, dy;
  logic [W_D-1:0] adx, ady;
  logic [2*D_HI-1:0]      hh_x, hh_y;
  logic [D_HI+D_LO-1:0]   hl_x, hl_y;
  logic [2*D_LO-1:0]      ll_x, ll_y;
  logic [W_SQ-1:0] sq_x, sq_y;

  assign dx = cx - px;
  assign dy = cy - py;

  always_ff @(posedge clk) begin
    adx <= dx[W_CTR-1] ? W_D'(-dx) : W_D'(dx);
    ady <= dy[W_CTR-1] ? W_D'(-dy) : W_D'(dy);

    hh_x <= adx[W_D-1:D_LO] * adx[W_D-1:D_LO];
    hl_x <= adx[W_D-1:D_LO] * adx[D_LO-1:0];
    ll_x <= adx[D_LO-1:0] * adx[D_LO-1:0];
    hh_y <= ady[W_D-1:D_LO] * ady[W_D-1:D_LO];
    hl_y <= ady[W_D-1:D_LO] * ady[D_LO-1:0];
    ll_y <= ady[D_LO-1:0] * ady[D_LO-1:0];

    // d^2 = h^2 * 2^(2L) + h*l * 2^(L+1) + l^2
    sq_x <= (W_SQ'(hh_x) << (2 * D_LO)) + (W_SQ'(hl_x) << (D_LO + 1)) + W_SQ'(ll_x);
    sq_y <= (W_SQ'(hh_y) << (2 * D_LO)) + (W_SQ'(hl_y) << (D_LO + 1)) + W_SQ'(ll_y);

    dsq <= sq_x + sq_y;
  end

endmodule

// File: design/hex_cell_from_point.sv
`timescale 1ns / 1ps

// Hex cell lookup: maps a point to the cell of a grid of shifted and unshifted
// rows, one point per clock while busy is low. A word is taken at a clock edge
// with start high and busy low; busy is high during reset and drops at the
// first clock edge that samples reset low. The result comes back with done
// high for one cycle, in order; the receiver cannot stall, so it must take
// every result as it appears. The latency is set by the multiply chain: scale,
// index times pitch, and the split 37-bit squares of the distance compare.
// Pitch and reciprocal registers are written through wr_en / wr_index /
// wr_data and must only change while no word is in flight.
module hex_cell_from_point import hcfp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [W_IN-1:0]    scene_x,
  input  logic signed [W_IN-1:0]    scene_y,
  input  logic                      wr_en,
  input  logic        [1:0]         wr_index,
  input  logic        [W_CFG-1:0]   wr_data,
  output logic                      done,
  output logic signed [W_IDX-1:0]   cell_col,
  output logic signed [W_IDX-1:0]   cell_row,
  output logic                      cell_unshifted,
  output logic signed [W_OUTC-1:0]  center_x,
  output logic signed [W_OUTC-1:0]  center_y
);

  logic [W_PITCH-1:0] col_pitch, row_pitch;
  logic [W_RECIP-1:0] col_recip, row_recip;
  logic [LATENCY-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pitch <= COL_PITCH_RST;
      row_pitch <= ROW_PITCH_RST;
      col_recip <= COL_RECIP_RST;
      row_recip <= ROW_RECIP_RST;
      busy      <= 1'b1;
      vpipe     <= '0;
    end else begin
      busy  <= 1'b0;
      vpipe <= {vpipe[LATENCY-2:0], start & ~busy};
      if (wr_en) begin
        case (cfg_reg_t'(wr_index))
          REG_COL_PITCH: col_pitch <= wr_data[W_PITCH-1:0];
          REG_ROW_PITCH: row_pitch <= wr_data[W_PITCH-1:0];
          REG_COL_RECIP: col_recip <= wr_data[W_RECIP-1:0];
          REG_ROW_RECIP: row_recip <= wr_data[W_RECIP-1:0];
          default: ;
        endcase
      end
    end
  end

  assign done = vpipe[LATENCY-1];

  // stage 1: capture
  logic signed [W_IN-1:0] sx1, sy1;
  // stage 2: scaled, Q24
  logic signed [W_IN-1:0] sx2, sy2;
  logic signed [W_SCALED-1:0] scx, scy;
  // stage 3: candidate indices
  logic signed [W_IN-1:0] sx3, sy3;
  logic signed [W_IDX-1:0] col_sh3, row_sh3, col_un3, row_un3;
  // stage 4: index times pitch
  logic signed [W_IN-1:0] sx4, sy4;
  logic signed [W_IDX-1:0] col_sh4, row_sh4, col_un4, row_un4;
  logic signed [W_CTR-1:0] pcx_sh, pcy_sh, pcx_un, pcy_un;
  // stage 5: centers
  logic signed [W_IN-1:0] sx5, sy5;
  logic signed [W_IDX-1:0] col_sh5, row_sh5, col_un5, row_un5;
  logic signed [W_CTR-1:0] cx_sh5, cy_sh5, cx_un5, cy_un5;

  logic signed [W_SCALED-1:0] rnd_x, rnd_y;
  logic signed [W_IDX:0] trn_x, trn_y;

  assign rnd_x = scx + HALF_Q24;
  assign rnd_y = scy + HALF_Q24;
  // floor plus one when negative with a fraction: truncation toward zero
  assign trn_x = scx[W_SCALED-1:FRAC_Q24] + (W_IDX+1)'(scx[W_SCALED-1] & (|scx[FRAC_Q24-1:0]));
  assign trn_y = scy[W_SCALED-1:FRAC_Q24] + (W_IDX+1)'(scy[W_SCALED-1] & (|scy[FRAC_Q24-1:0]));

  always_ff @(posedge clk) begin
    sx1 <= scene_x;
    sy1 <= scene_y;

    sx2 <= sx1;
    sy2 <= sy1;
    scx <= sx1 * $signed({1'b0, col_recip});
    scy <= sy1 * $signed({1'b0, row_recip});

    sx3 <= sx2;
    sy3 <= sy2;
    col_sh3 <= trn_x[W_IDX-1:0];
    row_sh3 <= trn_y[W_IDX-1:0];
    col_un3 <= rnd_x[FRAC_Q24+W_IDX-1:FRAC_Q24];
    row_un3 <= rnd_y[FRAC_Q24+W_IDX-1:FRAC_Q24];

    sx4 <= sx3;
    sy4 <= sy3;
    col_sh4 <= col_sh3;
    row_sh4 <= row_sh3;
    col_un4 <= col_un3;
    row_un4 <= row_un3;
    pcx_sh <= col_sh3 * $signed({1'b0, col_pitch});
    pcy_sh <= row_sh3 * $signed({1'b0, row_pitch});
    pcx_un <= col_un3 * $signed({1'b0, col_pitch});
    pcy_un <= row_un3 * $signed({1'b0, row_pitch});

    sx5 <= sx4;
    sy5 <= sy4;
    col_sh5 <= col_sh4;
    row_sh5 <= row_sh4;
    col_un5 <= col_un4;
    row_un5 <= row_un4;
    cx_sh5 <= pcx_sh + $signed(W_CTR'(col_pitch >> 1));
    cy_sh5 <= pcy_sh + $signed(W_CTR'(row_pitch >> 1));
    cx_un5 <= pcx_un;
    cy_un5 <= pcy_un;
  end

  logic signed [W_IN+7:0] px24, py24;
  logic signed [W_CTR-1:0] px5, py5;

  assign px24 = {sx5, 8'h00};
  assign py24 = {sy5, 8'h00};
  assign px5  = W_CTR'(px24);
  assign py5  = W_CTR'(py24);

  logic [W_SQ-1:0] dsq_sh, dsq_un;

  hcfp_dist_sq u_dist_sh (
    .clk (clk),
    .cx  (cx_sh5),
    .cy  (cy_sh5),
    .px  (px5),
    .py  (py5),
    .dsq (dsq_sh)
  );

  hcfp_dist_sq u_dist_un (
    .clk (clk),
    .cx  (cx_un5),
    .cy  (cy_un5),
    .px  (px5),
    .py  (py5),
    .dsq (dsq_un)
  );

  side_t side6;
  side_t side_d [SIDE_DEPTH];
  side_t side9;

  always_ff @(posedge clk) begin
    side6.col_sh <= col_sh5;
    side6.row_sh <= row_sh5;
    side6.col_un <= col_un5;
    side6.row_un <= row_un5;
    side6.cx_sh  <= sat_center(cx_sh5);
    side6.cy_sh  <= sat_center(cy_sh5);
    side6.cx_un  <= sat_center(cx_un5);
    side6.cy_un  <= sat_center(cy_un5);
    side_d[0] <= side6;
    for (int i = 1; i < SIDE_DEPTH; i++) begin
      side_d[i] <= side_d[i-1];
    end
  end

  assign side9 = side_d[SIDE_DEPTH-1];

  logic take_sh;
  assign take_sh = dsq_sh < dsq_un;

  always_ff @(posedge clk) begin
    cell_col       <= take_sh ? side9.col_sh : side9.col_un;
    cell_row       <= take_sh ? side9.row_sh : side9.row_un;
    cell_unshifted <= ~take_sh;
    center_x       <= take_sh ? side9.cx_sh : side9.cx_un;
    center_y       <= take_sh ? side9.cy_sh : side9.cy_un;
  end

endmodule

// File: design/hcfp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcfp_checker import hcfp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `HCFP_ASSERT_IMP(a_result_latency, start && !busy, ##LATENCY done, "accepted word gave no result")
  `HCFP_ASSERT_IMP(a_no_stray_done, done, $past(start && !busy, LATENCY), "result without a word")
  `HCFP_ASSERT_NXT(a_reset_flush, rst, busy && !done, "reset did not flush the pipeline")
  `HCFP_ASSERT_NXT(a_busy_release, !rst, !busy, "busy held outside reset")

endmodule

bind hex_cell_from_point hcfp_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import hcfp_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POINTS_PER_SETTING = 90;
  localparam int SETTING_COUNT = 6;
  localparam int MAX_REPORTS = 40;
  localparam longint CTR_HI = 16777215;
  localparam longint CTR_LO = -16777216;

  typedef struct packed {
    logic signed [W_IDX-1:0]  col;
    logic signed [W_IDX-1:0]  row;
    logic                     unshifted;
    logic signed [W_OUTC-1:0] cx;
    logic signed [W_OUTC-1:0] cy;
  } cell_t;

  typedef struct packed {
    logic                    is_setting;
    logic [3:0][W_CFG-1:0]   regs;
    logic signed [W_IN-1:0]  x;
    logic signed [W_IN-1:0]  y;
    logic                    typed;
    cell_t                   want;
  } step_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [W_IN-1:0]   scene_x = '0;
  logic signed [W_IN-1:0]   scene_y = '0;
  logic                     wr_en = 1'b0;
  logic [1:0]               wr_index = REG_COL_PITCH;
  logic [W_CFG-1:0]         wr_data = '0;
  logic                     done;
  logic signed [W_IDX-1:0]  cell_col;
  logic signed [W_IDX-1:0]  cell_row;
  logic                     cell_unshifted;
  logic signed [W_OUTC-1:0] center_x;
  logic signed [W_OUTC-1:0] center_y;

  longint grid_col_pitch = COL_PITCH_RST;
  longint grid_row_pitch = ROW_PITCH_RST;
  longint grid_col_recip = COL_RECIP_RST;
  longint grid_row_recip = ROW_RECIP_RST;

  cell_t pending_cells[$];
  int mismatches = 0;
  int results_seen = 0;
  int points_sent = 0;
  int settings_used = 1;
  int cycle_count = 0;

  hex_cell_from_point u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .scene_x        (scene_x),
    .scene_y        (scene_y),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .done           (done),
    .cell_col       (cell_col),
    .cell_row       (cell_row),
    .cell_unshifted (cell_unshifted),
    .center_x       (center_x),
    .center_y       (center_y)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_cells.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [127:0] square_abs(input longint d);
    logic [127:0] m;
    m = '0;
    m[63:0] = (d < 0) ? -d : d;
    return m * m;
  endfunction

  function automatic logic signed [W_OUTC-1:0] clamp_center(input longint v);
    if (v > CTR_HI) return W_OUTC'(CTR_HI);
    if (v < CTR_LO) return W_OUTC'(CTR_LO);
    return W_OUTC'(v);
  endfunction

  // truncated index -> shifted cell (center plus half pitch),
  // rounded index -> unshifted cell; shifted wins only when strictly closer
  function automatic cell_t locate_cell(input logic signed [W_IN-1:0] x,
                                        input logic signed [W_IN-1:0] y);
    longint sx, sy, scaled_x, scaled_y;
    longint tr_col, tr_row, rd_col, rd_row;
    longint tr_cx, tr_cy, rd_cx, rd_cy, px, py;
    logic [127:0] d_tr, d_rd;
    cell_t c;
    sx = x;
    sy = y;
    scaled_x = sx * grid_col_recip;
    scaled_y = sy * grid_row_recip;
    tr_col = (scaled_x < 0) ? -((-scaled_x) >>> 24) : (scaled_x >>> 24);
    tr_row = (scaled_y < 0) ? -((-scaled_y) >>> 24) : (scaled_y >>> 24);
    rd_col = (scaled_x + (longint'(1) << 23)) >>> 24;
    rd_row = (scaled_y + (longint'(1) << 23)) >>> 24;
    tr_cx = tr_col * grid_col_pitch + (grid_col_pitch >>> 1);
    tr_cy = tr_row * grid_row_pitch + (grid_row_pitch >>> 1);
    rd_cx = rd_col * grid_col_pitch;
    rd_cy = rd_row * grid_row_pitch;
    px = sx * 256;
    py = sy * 256;
    d_tr = square_abs(tr_cx - px) + square_abs(tr_cy - py);
    d_rd = square_abs(rd_cx - px) + square_abs(rd_cy - py);
    if (d_tr < d_rd) begin
      c.col = W_IDX'(tr_col);
      c.row = W_IDX'(tr_row);
      c.unshifted = 1'b0;
      c.cx = clamp_center(tr_cx);
      c.cy = clamp_center(tr_cy);
    end else begin
      c.col = W_IDX'(rd_col);
      c.row = W_IDX'(rd_row);
      c.unshifted = 1'b1;
      c.cx = clamp_center(rd_cx);
      c.cy = clamp_center(rd_cy);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    cell_t want;
    if (!rst && done) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("result with none pending: col %0d row %0d",
                                  cell_col, cell_row));
      end else begin
        want = pending_cells.pop_front();
        results_seen++;
        if (cell_col !== want.col)
          report_mismatch($sformatf("cell_col %0d, expected %0d", cell_col, want.col));
        if (cell_row !== want.row)
          report_mismatch($sformatf("cell_row %0d, expected %0d", cell_row, want.row));
        if (cell_unshifted !== want.unshifted)
          report_mismatch($sformatf("cell_unshifted %0b, expected %0b",
                                    cell_unshifted, want.unshifted));
        if (center_x !== want.cx)
          report_mismatch($sformatf("center_x %0d, expected %0d", center_x, want.cx));
        if (center_y !== want.cy)
          report_mismatch($sformatf("center_y %0d, expected %0d", center_y, want.cy));
      end
    end
  end

  function automatic step_t point_step(input int x, input int y);
    step_t s;
    s = '0;
    s.x = W_IN'(x);
    s.y = W_IN'(y);
    return s;
  endfunction

  // expected: cell 0,0 unshifted, centered on the origin
  function automatic step_t origin_step(input int x, input int y);
    step_t s;
    s = point_step(x, y);
    s.typed = 1'b1;
    s.want.unshifted = 1'b1;
    return s;
  endfunction

  function automatic step_t setting_step(input logic [W_CFG-1:0] cp, input logic [W_CFG-1:0] rp,
                                         input logic [W_CFG-1:0] cr, input logic [W_CFG-1:0] rr);
    step_t s;
    s = '0;
    s.is_setting = 1'b1;
    s.regs[REG_COL_PITCH] = cp;
    s.regs[REG_ROW_PITCH] = rp;
    s.regs[REG_COL_RECIP] = cr;
    s.regs[REG_ROW_RECIP] = rr;
    return s;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_point(input logic signed [W_IN-1:0] x, input logic signed [W_IN-1:0] y,
                            input logic typed, input cell_t want);
    start <= 1'b1;
    scene_x <= x;
    scene_y <= y;
    do @(posedge clk); while (busy);
    pending_cells.push_back(typed ? want : locate_cell(x, y));
    points_sent++;
  endtask

  task automatic pause_driver(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // registers change only with nothing in flight
  task automatic apply_setting(input logic [3:0][W_CFG-1:0] regs);
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      wr_en <= 1'b1;
      wr_index <= cfg_reg_t'(i);
      wr_data <= regs[i];
      @(posedge clk);
      case (cfg_reg_t'(i))
        REG_COL_PITCH: grid_col_pitch = regs[i][W_PITCH-1:0];
        REG_ROW_PITCH: grid_row_pitch = regs[i][W_PITCH-1:0];
        REG_COL_RECIP: grid_col_recip = regs[i][W_RECIP-1:0];
        REG_ROW_RECIP: grid_row_recip = regs[i][W_RECIP-1:0];
      endcase
    end
    wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    step_t steps[$];
    logic [3:0][W_CFG-1:0] regs;
    logic signed [W_IN-1:0] x, y;
    longint cp, rp, v;
    bit calm;

    // reset registers
    steps.push_back(origin_step(0, 0));
    steps.push_back(point_step(32767, 32767));
    steps.push_back(point_step(-32768, -32768));
    steps.push_back(point_step(32767, -32768));
    steps.push_back(point_step(-32768, 32767));
    steps.push_back(point_step(-1, 1));
    steps.push_back(point_step(1, -1));
    // all ones; pitch upper bits dropped, far centers saturate
    steps.push_back(setting_step(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    steps.push_back(point_step(32767, 32767));
    steps.push_back(point_step(-32768, -32768));
    steps.push_back(origin_step(0, 0));
    // all zero: both candidates at the origin, tie goes unshifted
    steps.push_back(setting_step(24'd0, 24'd0, 24'd0, 24'd0));
    steps.push_back(origin_step(12345, -12345));
    steps.push_back(origin_step(-32768, 32767));
    // reciprocal one half: negative half steps round toward +inf
    steps.push_back(setting_step(24'd512, 24'd512, 24'h800000, 24'h800000));
    steps.push_back(point_step(-3, -3));
    steps.push_back(point_step(-1, -1));
    steps.push_back(point_step(3, 1));
    steps.push_back(point_step(-5, 2));
    steps.push_back(setting_step(24'd1, 24'd1, 24'd1, 24'd1));
    steps.push_back(point_step(32767, -32768));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].is_setting) begin
        apply_setting(steps[i].regs);
      end else begin
        send_point(steps[i].x, steps[i].y, steps[i].typed, steps[i].want);
        if (i + 1 < steps.size() && !steps[i + 1].is_setting) pause_driver(pick_gap(1'b0));
      end
    end

    for (int ph = 0; ph < SETTING_COUNT; ph++) begin
      case (ph)
        0: begin
          regs[REG_COL_PITCH] = W_CFG'(COL_PITCH_RST);
          regs[REG_ROW_PITCH] = W_CFG'(ROW_PITCH_RST);
          regs[REG_COL_RECIP] = W_CFG'(COL_RECIP_RST);
          regs[REG_ROW_RECIP] = W_CFG'(ROW_RECIP_RST);
        end
        1, 2: begin
          cp = (ph == 1) ? $urandom_range(257, 4000) : $urandom_range(100000, 1048575);
          rp = (ph == 1) ? $urandom_range(257, 6000) : $urandom_range(100000, 1048575);
          regs[REG_COL_PITCH] = W_CFG'(cp);
          regs[REG_ROW_PITCH] = W_CFG'(rp);
          regs[REG_COL_RECIP] = W_CFG'((longint'(1) << 32) / cp);
          regs[REG_ROW_RECIP] = W_CFG'((longint'(1) << 32) / rp);
        end
        3: begin
          for (int i = 0; i < 4; i++) regs[i] = W_CFG'($urandom);
        end
        4: begin
          for (int i = 0; i < 4; i++) regs[i] = '1;
        end
        default: begin
          for (int i = 0; i < 4; i++) regs[i] = W_CFG'(1);
        end
      endcase
      apply_setting(regs);

      calm = 1'b0;
      for (int n = 0; n < POINTS_PER_SETTING; n++) begin
        if (n % 16 == 0) calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 4))
          0, 1: begin
            x = W_IN'($urandom);
            y = W_IN'($urandom);
          end
          2, 3: begin
            x = W_IN'(int'($urandom_range(0, 1200)) - 600);
            y = W_IN'(int'($urandom_range(0, 1200)) - 600);
          end
          default: begin
            // near a half-pitch line, where the two candidates compete
            v = ((longint'($urandom_range(0, 80)) - 40) * grid_col_pitch) >>> 9;
            x = W_IN'(v + int'($urandom_range(0, 4)) - 2);
            v = ((longint'($urandom_range(0, 80)) - 40) * grid_row_pitch) >>> 9;
            y = W_IN'(v + int'($urandom_range(0, 4)) - 2);
          end
        endcase
        send_point(x, y, 1'b0, '0);
        if (n + 1 < POINTS_PER_SETTING) pause_driver(pick_gap(calm));
      end
    end

    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("%0d points sent under %0d register settings (reset, zero, ones, max,",
             points_sent, settings_used);
    $display("half step, matched and random grids); %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
